>>> hdl/srlb_pkg.sv
// Shared types, codes and arithmetic helpers for the raster line and blur engine.
// Used by srlb_ctrl, srlb_datapath and scope_raster_line_blur_engine_top.
// No dependencies.
package srlb_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_BLUR  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BEAM   = 2'd2;

  localparam logic [7:0]  SIZE_RESET = 8'd128;
  localparam logic [23:0] BEAM_RESET = 24'h002000;
  localparam logic [7:0]  CHAN_MAX   = 8'hff;
  // floor(s/30) == (s*2185) >> 16 for every s below 4709
  localparam logic [11:0] BLUR_RECIP = 12'd2185;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CLEAR,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_BLUR_C,
    ST_BLUR_UP,
    ST_BLUR_RT,
    ST_BLUR_DN,
    ST_BLUR_WR,
    ST_READ_RD,
    ST_READ_CAP,
    ST_DONE
  } state_t;

  // Read address select
  typedef enum logic [2:0] {
    RA_K,
    RA_UP,
    RA_RT,
    RA_DN,
    RA_LINE
  } rsel_t;

  // Write data select
  typedef enum logic [1:0] {
    WS_ZERO,
    WS_PLOT,
    WS_BLUR
  } wsel_t;

  // Blur neighbor capture
  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_C,
    CAP_UP,
    CAP_RT
  } cap_t;

  typedef struct packed {
    logic  load;
    logic  line_step;
    logic  plot_latch;
    logic  pix_latch;
    rsel_t rsel;
    logic  we;
    wsel_t wsel;
    logic  k_clr;
    logic  k_inc;
    cap_t  cap;
    logic  out_load;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic line_done;
    logic k_zero;
    logic k_last_clr;
    logic k_last_blur;
    logic out_free;
    logic cfg_clr;
  } dp_stat_t;

  // Additive blend of one channel, saturating
  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? CHAN_MAX : s[7:0];
  endfunction

  // (5*c + u + l + r + d) / 30 for one channel
  function automatic logic [7:0] blur_chan(input logic [7:0] c, input logic [7:0] u,
                                           input logic [7:0] l, input logic [7:0] r,
                                           input logic [7:0] d);
    logic [11:0] s;
    logic [23:0] p;
    s = 12'(c) * 12'd5 + 12'(u) + 12'(l) + 12'(r) + 12'(d);
    p = 24'(s) * 24'(BLUR_RECIP);
    return p[23:16];
  endfunction

endpackage

>>> hdl/srlb_ctrl.sv
// Sequencer for the raster line and blur engine: one state machine that steps
// the datapath through clear, draw, blur and read. Depends on srlb_pkg.
module srlb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  srlb_pkg::dp_stat_t stat,
  output srlb_pkg::dp_cmd_t  cmd
);

  srlb_pkg::state_t state_r, state_nxt;
  logic             clr_item_r, clr_item_nxt;

  // State register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= srlb_pkg::ST_CLEAR;
      clr_item_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_item_r <= clr_item_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    clr_item_nxt = clr_item_r;
    cmd          = '0;
    in_tready    = 1'b0;
    case (state_r)
      srlb_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = srlb_pkg::ST_DISPATCH;
        end
      end
      srlb_pkg::ST_DISPATCH: begin
        case (stat.op)
          srlb_pkg::OP_DRAW: state_nxt = srlb_pkg::ST_DRAW_RD;
          srlb_pkg::OP_BLUR: begin
            cmd.k_clr = 1'b1;
            state_nxt = srlb_pkg::ST_BLUR_C;
          end
          srlb_pkg::OP_CLEAR: begin
            cmd.k_clr    = 1'b1;
            clr_item_nxt = 1'b1;
            state_nxt    = srlb_pkg::ST_CLEAR;
          end
          default: state_nxt = srlb_pkg::ST_READ_RD;
        endcase
      end
      srlb_pkg::ST_CLEAR: begin
        cmd.we    = 1'b1;
        cmd.wsel  = srlb_pkg::WS_ZERO;
        cmd.k_inc = 1'b1;
        if (stat.k_last_clr) begin
          state_nxt    = clr_item_r ? srlb_pkg::ST_DONE : srlb_pkg::ST_IDLE;
          clr_item_nxt = 1'b0;
        end
      end
      srlb_pkg::ST_DRAW_RD: begin
        cmd.rsel       = srlb_pkg::RA_LINE;
        cmd.plot_latch = 1'b1;
        state_nxt      = srlb_pkg::ST_DRAW_WR;
      end
      srlb_pkg::ST_DRAW_WR: begin
        cmd.we        = 1'b1;
        cmd.wsel      = srlb_pkg::WS_PLOT;
        cmd.line_step = 1'b1;
        state_nxt     = stat.line_done ? srlb_pkg::ST_DONE : srlb_pkg::ST_DRAW_RD;
      end
      srlb_pkg::ST_BLUR_C: begin
        cmd.rsel  = srlb_pkg::RA_K;
        state_nxt = srlb_pkg::ST_BLUR_UP;
      end
      srlb_pkg::ST_BLUR_UP: begin
        cmd.rsel  = srlb_pkg::RA_UP;
        cmd.cap   = stat.k_zero ? srlb_pkg::CAP_C : srlb_pkg::CAP_NONE;
        state_nxt = srlb_pkg::ST_BLUR_RT;
      end
      srlb_pkg::ST_BLUR_RT: begin
        cmd.rsel  = srlb_pkg::RA_RT;
        cmd.cap   = srlb_pkg::CAP_UP;
        state_nxt = srlb_pkg::ST_BLUR_DN;
      end
      srlb_pkg::ST_BLUR_DN: begin
        cmd.rsel  = srlb_pkg::RA_DN;
        cmd.cap   = srlb_pkg::CAP_RT;
        state_nxt = srlb_pkg::ST_BLUR_WR;
      end
      srlb_pkg::ST_BLUR_WR: begin
        cmd.we   = 1'b1;
        cmd.wsel = srlb_pkg::WS_BLUR;
        if (stat.k_last_blur) begin
          state_nxt = srlb_pkg::ST_DONE;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = srlb_pkg::ST_BLUR_UP;
        end
      end
      srlb_pkg::ST_READ_RD: begin
        cmd.rsel  = srlb_pkg::RA_LINE;
        state_nxt = srlb_pkg::ST_READ_CAP;
      end
      srlb_pkg::ST_READ_CAP: begin
        cmd.pix_latch = 1'b1;
        state_nxt     = srlb_pkg::ST_DONE;
      end
      srlb_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = srlb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = srlb_pkg::ST_IDLE;
    endcase

    // Frame size change restarts the clearing pass; no transfer in that cycle
    if (stat.cfg_clr) begin
      in_tready    = 1'b0;
      cmd.load     = 1'b0;
      cmd.k_clr    = 1'b1;
      cmd.k_inc    = 1'b0;
      clr_item_nxt = 1'b0;
      state_nxt    = srlb_pkg::ST_CLEAR;
    end
  end

endmodule

>>> hdl/srlb_datapath.sv
// Datapath of the raster line and blur engine: config registers, frame memory,
// line walker, blend and blur arithmetic, result register. Depends on srlb_pkg.
module srlb_datapath #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [39:0]        in_tdata,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  srlb_pkg::dp_cmd_t  cmd,
  output srlb_pkg::dp_stat_t stat,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);

  // Configuration registers
  logic [7:0]  width_r, height_r;
  logic [23:0] beam_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= srlb_pkg::SIZE_RESET;
      height_r <= srlb_pkg::SIZE_RESET;
      beam_r   <= srlb_pkg::BEAM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        srlb_pkg::REG_WIDTH:  width_r  <= cfg_data[7:0];
        srlb_pkg::REG_HEIGHT: height_r <= cfg_data[7:0];
        srlb_pkg::REG_BEAM:   beam_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective frame size
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [NW-1:0] n_pix;

  always_comb begin
    if (width_r == 8'd0) eff_w = WW'(1);
    else if (32'(width_r) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(width_r);
    if (height_r == 8'd0) eff_h = HW'(1);
    else if (32'(height_r) > MAX_HEIGHT) eff_h = HW'(MAX_HEIGHT);
    else eff_h = HW'(height_r);
  end
  assign n_pix = NW'(eff_w) * NW'(eff_h);

  // Item fields and line walker state
  srlb_pkg::op_t       op_r;
  logic [6:0]          x_r, y_r, ex_r, ey_r;
  logic [6:0]          dx_r;
  logic signed [9:0]   dy_r, err_r;
  logic                xneg_r, yneg_r;
  logic [2:0][7:0]     scale_r;

  logic [6:0]  isx, isy, iex, iey, idx, idy;
  logic [8:0]  ibr;
  logic [16:0] prod [3];

  assign isx = in_tdata[8:2];
  assign isy = in_tdata[15:9];
  assign iex = in_tdata[22:16];
  assign iey = in_tdata[29:23];
  assign ibr = (in_tdata[38:30] > 9'd256) ? 9'd256 : in_tdata[38:30];
  assign idx = (isx > iex) ? isx - iex : iex - isx;
  assign idy = (isy > iey) ? isy - iey : iey - isy;

  // Beam color scaled by brightness, one product per channel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = 17'(beam_r[c*8 +: 8]) * 17'(ibr);
    end
  end

  // Bresenham step decision
  logic signed [10:0] e2;
  logic               go_x, go_y, line_done;
  logic signed [9:0]  err_nxt;

  assign e2        = {err_r, 1'b0};
  assign go_x      = e2 >= 11'(dy_r);
  assign go_y      = e2 <= $signed({4'b0, dx_r});
  assign line_done = (x_r == ex_r && y_r == ey_r) || (go_x && x_r == ex_r) ||
                     (go_y && y_r == ey_r);
  assign err_nxt   = err_r + (go_x ? dy_r : 10'sd0) + (go_y ? $signed({3'b0, dx_r}) : 10'sd0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= srlb_pkg::op_t'(in_tdata[1:0]);
      x_r     <= isx;
      y_r     <= isy;
      ex_r    <= iex;
      ey_r    <= iey;
      dx_r    <= idx;
      dy_r    <= -$signed({3'b0, idy});
      err_r   <= $signed({3'b0, idx}) - $signed({3'b0, idy});
      xneg_r  <= !(isx < iex);
      yneg_r  <= !(isy < iey);
      for (int c = 0; c < 3; c++) scale_r[c] <= prod[c][15:8];
    end else if (cmd.line_step && !line_done) begin
      err_r <= err_nxt;
      if (go_x) x_r <= xneg_r ? x_r - 7'd1 : x_r + 7'd1;
      if (go_y) y_r <= yneg_r ? y_r - 7'd1 : y_r + 7'd1;
    end
  end

  // Current line pixel: frame test and linear address
  logic          line_in;
  logic [NW-1:0] line_lin;

  assign line_in  = (32'(x_r) < 32'(eff_w)) && (32'(y_r) < 32'(eff_h));
  assign line_lin = NW'(y_r) * NW'(eff_w) + NW'(x_r);

  // Sweep counter for clear and blur
  logic [NW-1:0] k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) k_r <= '0;
    else if (cmd.k_clr) k_r <= '0;
    else if (cmd.k_inc) k_r <= k_r + NW'(1);
  end

  logic up_ok, lf_ok, rt_ok, dn_ok;
  assign up_ok = k_r >= NW'(eff_w);
  assign lf_ok = k_r != '0;
  assign rt_ok = ({1'b0, k_r} + (NW+1)'(1)) < {1'b0, n_pix};
  assign dn_ok = ({1'b0, k_r} + (NW+1)'(eff_w)) < {1'b0, n_pix};

  // Frame memory
  logic [23:0]   mem [DEPTH];
  logic [23:0]   rdata_r, wdata;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [AW-1:0] plot_addr_r;
  logic          plot_ok_r;

  always_comb begin
    case (cmd.rsel)
      srlb_pkg::RA_UP:   raddr = AW'(k_r - NW'(eff_w));
      srlb_pkg::RA_RT:   raddr = AW'(k_r + NW'(1));
      srlb_pkg::RA_DN:   raddr = AW'(k_r + NW'(eff_w));
      srlb_pkg::RA_LINE: raddr = AW'(line_lin);
      default:           raddr = AW'(k_r);
    endcase
  end

  // Blur neighbors
  logic [23:0] c_r, up_r, rt_r, lf_r, blur_res, plot_res;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      blur_res[c*8 +: 8] = srlb_pkg::blur_chan(c_r[c*8 +: 8],
                                              up_ok ? up_r[c*8 +: 8] : 8'd0,
                                              lf_ok ? lf_r[c*8 +: 8] : 8'd0,
                                              rt_ok ? rt_r[c*8 +: 8] : 8'd0,
                                              dn_ok ? rdata_r[c*8 +: 8] : 8'd0);
      plot_res[c*8 +: 8] = srlb_pkg::sat_add(rdata_r[c*8 +: 8], scale_r[c]);
    end
  end

  always_comb begin
    case (cmd.wsel)
      srlb_pkg::WS_PLOT: begin
        wdata = plot_res;
        waddr = plot_addr_r;
        we    = cmd.we && plot_ok_r;
      end
      srlb_pkg::WS_BLUR: begin
        wdata = blur_res;
        waddr = AW'(k_r);
        we    = cmd.we;
      end
      default: begin
        wdata = '0;
        waddr = AW'(k_r);
        we    = cmd.we;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.plot_latch) begin
      plot_addr_r <= AW'(line_lin);
      plot_ok_r   <= line_in;
    end
    case (cmd.cap)
      srlb_pkg::CAP_C:  c_r  <= rdata_r;
      srlb_pkg::CAP_UP: up_r <= rdata_r;
      srlb_pkg::CAP_RT: rt_r <= rdata_r;
      default: ;
    endcase
    // Blurred pixel becomes the next left; the old right becomes the next center
    if (cmd.we && cmd.wsel == srlb_pkg::WS_BLUR) begin
      lf_r <= blur_res;
      c_r  <= rt_r;
    end
  end

  // Result register
  logic        out_valid_r;
  logic [1:0]  out_op_r;
  logic [23:0] pix_r, out_pix_r;

  always_ff @(posedge clk) begin
    if (cmd.pix_latch) pix_r <= line_in ? rdata_r : 24'd0;
    if (cmd.out_load) begin
      out_op_r  <= op_r;
      out_pix_r <= (op_r == srlb_pkg::OP_READ) ? pix_r : 24'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_pix_r[7:0], out_pix_r[15:8], out_pix_r[23:16], out_op_r};

  // Status to the controller
  assign stat.op          = op_r;
  assign stat.line_done   = line_done;
  assign stat.k_zero      = k_r == '0;
  assign stat.k_last_clr  = k_r == NW'(DEPTH - 1);
  assign stat.k_last_blur = k_r == n_pix - NW'(1);
  assign stat.out_free    = !out_valid_r || out_tready;
  assign stat.cfg_clr     = cfg_we &&
                            (cfg_index == srlb_pkg::REG_WIDTH || cfg_index == srlb_pkg::REG_HEIGHT);

endmodule

>>> hdl/scope_raster_line_blur_engine_top.sv
// One item at a time, set by the frame memory sweep. Reset (synchronous,
// rst_n low) and any frame_width or frame_height write start a clearing pass
// over MAX_WIDTH*MAX_HEIGHT words, one word a cycle, during which in_tready is
// low. Result held in an output register; the next item is taken while a
// result waits.
module scope_raster_line_blur_engine_top #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation[1:0], start_x[8:2], start_y[15:9], end_x[22:16], end_y[29:23],
  // brightness[38:30]
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // finished_operation[1:0], pixel_red[9:2], pixel_green[17:10], pixel_blue[25:18]
  output logic [31:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  srlb_pkg::dp_cmd_t  cmd;
  srlb_pkg::dp_stat_t stat;

  srlb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  srlb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Frame size change blocks input while the store is cleared
  a_size_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == srlb_pkg::REG_WIDTH || cfg_index == srlb_pkg::REG_HEIGHT)
    |=> !in_tready)
    else $error("input ready right after frame size write");

  // One item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transfer");

  // A new result only comes out of a busy cycle
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while idle");

endmodule

>>> verif/scope_raster_line_blur_engine_top_tb.sv
// Self-checking testbench for scope_raster_line_blur_engine_top: directed and random
// draw/blur/clear/read items checked against an in-bench frame predictor.
// Depends on hdl/srlb_pkg.sv and the top-level RTL.
module scope_raster_line_blur_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_WORDS = 128 * 128;
  localparam int STALL_LIMIT = 200000;

  typedef struct {
    srlb_pkg::op_t op;
    logic [7:0]    red;
    logic [7:0]    green;
    logic [7:0]    blue;
  } pixel_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  scope_raster_line_blur_engine_top dut (.*);

  // predictor state
  logic [23:0]   frame_mem [0:FRAME_WORDS-1];
  logic [7:0]    width_reg;
  logic [7:0]    height_reg;
  logic [23:0]   beam_reg;
  pixel_result_t pending_results [$];

  int error_count;
  int sent_count;
  int checked_count;
  int op_count [4];
  int idle_pct;
  int stall_pct;
  int quiet_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > 128) return 128;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > 128) return 128;
    return height_reg;
  endfunction

  function automatic void wipe_frame();
    foreach (frame_mem[i]) frame_mem[i] = '0;
  endfunction

  // additive saturating blend of the beam at one pixel
  function automatic void blend_pixel(int x, int y, int unsigned bright);
    int unsigned w, h, k, v;
    logic [23:0] old, res;
    w = eff_width();
    h = eff_height();
    if (x < 0 || y < 0 || x >= w || y >= h) return;
    k = y * w + x;
    old = frame_mem[k];
    res = '0;
    for (int sh = 0; sh <= 16; sh += 8) begin
      v = ((old >> sh) & 8'hff) + ((((beam_reg >> sh) & 8'hff) * bright) >> 8);
      if (v > 255) v = 255;
      res |= 24'(v) << sh;
    end
    frame_mem[k] = res;
  endfunction

  // Bresenham walk
  function automatic void trace_line(int x0, int y0, int x1, int y1, int unsigned bright);
    int x, y, dx, dy, sx, sy, err, e2;
    x = x0;
    y = y0;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = -((y1 > y0) ? y1 - y0 : y0 - y1);
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = dx + dy;
    while (1) begin
      blend_pixel(x, y, bright);
      if (x == x1 && y == y1) break;
      e2 = 2 * err;
      if (e2 >= dy) begin
        if (x == x1) break;
        err += dy;
        x += sx;
      end
      if (e2 <= dx) begin
        if (y == y1) break;
        err += dx;
        y += sy;
      end
    end
  endfunction

  function automatic logic [23:0] neighbor(int k, int unsigned n);
    if (k < 0 || k >= n) return '0;
    return frame_mem[k];
  endfunction

  // in-place raster blur; up and left already updated
  function automatic void blur_frame();
    int unsigned w, n, s;
    logic [23:0] c, up, lf, rt, dn, res;
    w = eff_width();
    n = w * eff_height();
    for (int k = 0; k < n; k++) begin
      c  = frame_mem[k];
      up = neighbor(k - int'(w), n);
      lf = neighbor(k - 1, n);
      rt = neighbor(k + 1, n);
      dn = neighbor(k + int'(w), n);
      res = '0;
      for (int sh = 0; sh <= 16; sh += 8) begin
        s = 5 * ((c >> sh) & 8'hff) + ((up >> sh) & 8'hff) + ((lf >> sh) & 8'hff)
          + ((rt >> sh) & 8'hff) + ((dn >> sh) & 8'hff);
        res |= 24'((s / 30) & 8'hff) << sh;
      end
      frame_mem[k] = res;
    end
  endfunction

  function automatic pixel_result_t predict_item(srlb_pkg::op_t op, int sx, int sy,
                                                 int ex, int ey, int unsigned bright);
    pixel_result_t r;
    logic [23:0] pix;
    pix = '0;
    if (bright > 256) bright = 256;
    case (op)
      srlb_pkg::OP_DRAW:  trace_line(sx, sy, ex, ey, bright);
      srlb_pkg::OP_BLUR:  blur_frame();
      srlb_pkg::OP_CLEAR: wipe_frame();
      default: begin
        if (sx < eff_width() && sy < eff_height()) pix = frame_mem[sy * eff_width() + sx];
      end
    endcase
    r.op = op;
    r.red = pix[23:16];
    r.green = pix[15:8];
    r.blue = pix[7:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int exp_val);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, exp_val);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    pixel_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer, op", out_tdata[1:0], -1);
      end else begin
        e = pending_results.pop_front();
        checked_count++;
        if (out_tdata[1:0] != e.op) report_mismatch("finished_operation", out_tdata[1:0], e.op);
        if (out_tdata[9:2] != e.red) report_mismatch("pixel_red", out_tdata[9:2], e.red);
        if (out_tdata[17:10] != e.green)
          report_mismatch("pixel_green", out_tdata[17:10], e.green);
        if (out_tdata[25:18] != e.blue) report_mismatch("pixel_blue", out_tdata[25:18], e.blue);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one item; valid is left high after the transfer, the next call or go_quiet settles it
  task automatic send_item(srlb_pkg::op_t op, int sx, int sy, int ex, int ey,
                           int unsigned bright);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, 9'(bright), 7'(ey), 7'(ex), 7'(sy), 7'(sx), op};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_item(op, sx, sy, ex, ey, bright));
    sent_count++;
    op_count[op]++;
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    go_quiet();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] value);
    drain_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      srlb_pkg::REG_WIDTH: begin
        width_reg = value[7:0];
        wipe_frame();
      end
      srlb_pkg::REG_HEIGHT: begin
        height_reg = value[7:0];
        wipe_frame();
      end
      default: beam_reg = value;
    endcase
  endtask

  task automatic test_reset_state();
    send_item(srlb_pkg::OP_READ, 0, 0, 0, 0, 0);
    send_item(srlb_pkg::OP_READ, 127, 127, 0, 0, 0);
  endtask

  // diagonal, horizontal and vertical lines, a single point, zero and over-range brightness, saturation
  task automatic test_draw_extremes();
    send_item(srlb_pkg::OP_DRAW, 0, 0, 127, 127, 256);
    send_item(srlb_pkg::OP_DRAW, 127, 5, 0, 5, 511);
    send_item(srlb_pkg::OP_DRAW, 3, 127, 3, 0, 0);
    send_item(srlb_pkg::OP_DRAW, 9, 9, 9, 9, 128);
    write_reg(srlb_pkg::REG_BEAM, 24'hffffff);
    send_item(srlb_pkg::OP_DRAW, 0, 0, 127, 127, 256);
    send_item(srlb_pkg::OP_DRAW, 127, 127, 0, 0, 256);
    send_item(srlb_pkg::OP_READ, 64, 64, 0, 0, 0);
    send_item(srlb_pkg::OP_READ, 127, 127, 0, 0, 0);
    send_item(srlb_pkg::OP_READ, 3, 3, 0, 0, 0);
  endtask

  task automatic test_blur_and_clear();
    send_item(srlb_pkg::OP_BLUR, 0, 0, 0, 0, 0);
    send_item(srlb_pkg::OP_READ, 1, 1, 0, 0, 0);
    send_item(srlb_pkg::OP_READ, 0, 0, 0, 0, 0);
    send_item(srlb_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
    send_item(srlb_pkg::OP_READ, 64, 64, 0, 0, 0);
  endtask

  // zero and oversized dimensions, pixels outside the frame
  task automatic test_size_limits();
    write_reg(srlb_pkg::REG_WIDTH, 24'd0);
    write_reg(srlb_pkg::REG_HEIGHT, 24'd255);
    send_item(srlb_pkg::OP_DRAW, 0, 0, 5, 100, 256);
    send_item(srlb_pkg::OP_BLUR, 0, 0, 0, 0, 0);
    send_item(srlb_pkg::OP_READ, 0, 50, 0, 0, 0);
    send_item(srlb_pkg::OP_READ, 1, 0, 0, 0, 0);
    write_reg(srlb_pkg::REG_WIDTH, 24'd200);
    write_reg(srlb_pkg::REG_HEIGHT, 24'd0);
    send_item(srlb_pkg::OP_DRAW, 0, 0, 127, 3, 200);
    send_item(srlb_pkg::OP_BLUR, 0, 0, 0, 0, 0);
    send_item(srlb_pkg::OP_READ, 127, 0, 0, 0, 0);
  endtask

  function automatic int pick_coord(int unsigned lim);
    if ($urandom_range(9) == 0) return $urandom_range(127);
    return $urandom_range(lim - 1);
  endfunction

  // random items over small, minimal and clamped frame sizes, mostly drawing and reading back
  task automatic test_random(int items, bit pause_midway);
    int unsigned w, h, sel, br;
    srlb_pkg::op_t op;
    case ($urandom_range(5))
      0:       w = 0;
      1:       w = $urandom_range(129, 255);
      default: w = $urandom_range(1, 16);
    endcase
    h = ($urandom_range(5) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 16);
    write_reg(srlb_pkg::REG_WIDTH, 24'(w));
    write_reg(srlb_pkg::REG_HEIGHT, 24'(h));
    write_reg(srlb_pkg::REG_BEAM, 24'($urandom_range(24'hffffff)));
    for (int i = 0; i < items; i++) begin
      sel = $urandom_range(99);
      if (sel < 45) op = srlb_pkg::OP_DRAW;
      else if (sel < 87) op = srlb_pkg::OP_READ;
      else if (sel < 99) op = srlb_pkg::OP_BLUR;
      else op = srlb_pkg::OP_CLEAR;
      br = ($urandom_range(7) == 0) ? $urandom_range(257, 511) : $urandom_range(256);
      send_item(op, pick_coord(eff_width()), pick_coord(eff_height()),
                pick_coord(eff_width()), pick_coord(eff_height()), br);
      if (pause_midway && i == items / 2) drain_results();
    end
  endtask

  initial begin
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = srlb_pkg::REG_WIDTH;
    cfg_data = '0;
    rst_n = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    error_count = 0;
    sent_count = 0;
    checked_count = 0;
    foreach (op_count[i]) op_count[i] = 0;
    width_reg = srlb_pkg::SIZE_RESET;
    height_reg = srlb_pkg::SIZE_RESET;
    beam_reg = srlb_pkg::BEAM_RESET;
    wipe_frame();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_draw_extremes();
    test_blur_and_clear();
    test_size_limits();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      for (int s = 0; s < 3; s++) test_random(165, s == 1);
    end

    drain_results();
    repeat (100) @(posedge clk);
    $display("Covered %0d items (draw %0d, blur %0d, clear %0d, read %0d), %0d results checked,",
             sent_count, op_count[srlb_pkg::OP_DRAW], op_count[srlb_pkg::OP_BLUR],
             op_count[srlb_pkg::OP_CLEAR], op_count[srlb_pkg::OP_READ], checked_count);
    $display("over clamped, minimal and small frame sizes under four idle/stall mixes.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
